// ----- sv/fip_pkg.sv -----
// Shared types, constants and byte classifiers for the FASTA index parser.
// No dependencies; every other file of the block but fip_queue imports this package.
package fip_pkg;

    // Record kinds as they appear on the kind port.
    typedef enum logic [2:0] {
        K_CONTIG_START = 3'd0,
        K_NAME_BYTE    = 3'd1,
        K_NAME_END     = 3'd2,
        K_HEADER_START = 3'd3,
        K_SEQ_START    = 3'd4,
        K_CONTIG_END   = 3'd5,
        K_BAD_START    = 3'd6
    } kind_t;

    // Parser states.
    typedef enum logic [2:0] {
        PS_START   = 3'd0,
        PS_SEEK    = 3'd1,
        PS_NAME    = 3'd2,
        PS_COMMENT = 3'd3,
        PS_LINE    = 3'd4,
        PS_SEQ     = 3'd5
    } parse_state_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NEWLINE_SIZE = 3'd0;
    localparam logic [2:0] CFG_VALID_MAP_0  = 3'd1;
    localparam logic [2:0] CFG_VALID_MAP_1  = 3'd2;
    localparam logic [2:0] CFG_VALID_MAP_2  = 3'd3;
    localparam logic [2:0] CFG_VALID_MAP_3  = 3'd4;

    // Configuration reset values.
    localparam logic [1:0]  NEWLINE_SIZE_RESET = 2'd1;
    localparam logic [63:0] VALID_MAP_1_RESET  = 64'd4574561078100106;

    // Most records one byte can cause.
    localparam int MAX_RECORDS = 4;

    // Character codes.
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VTAB   = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // Control part of one bundle of records caused by a single byte.
    // A contig end in the last slot takes its data from set B, any other from set A.
    // Each slot carries its own name character, since one byte can emit two name bytes.
    typedef struct packed {
        logic [2:0]                        count;
        logic [MAX_RECORDS-1:0][2:0]       kind;
        logic [MAX_RECORDS-1:0][7:0]       name_char;
        logic                              regular_a;
        logic                              regular_b;
    } rec_ctl_t;

    function automatic logic is_newline(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF)
            || is_newline(c);
    endfunction

endpackage

// ----- sv/fip_front.sv -----
// Front end of the FASTA index parser: configuration registers, byte
// classification, parser state and the bundle of records for each byte.
// Depends on fip_pkg.
module fip_front #(
    parameter int OFFSET_BITS = 40
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    byte_en,
    input  logic [7:0]                              in_byte,
    input  logic                                    last,
    input  logic                                    cfg_valid,
    input  logic [2:0]                              cfg_index,
    input  logic [63:0]                             cfg_data,
    output logic                                    wr_en,
    output fip_pkg::rec_ctl_t                       ctl,
    output logic [fip_pkg::MAX_RECORDS-1:0][OFFSET_BITS-1:0] pos,
    output logic [OFFSET_BITS-1:0]                  end_a_res,
    output logic [OFFSET_BITS-1:0]                  end_a_len,
    output logic [OFFSET_BITS-1:0]                  end_b_res,
    output logic [OFFSET_BITS-1:0]                  end_b_len
);
    import fip_pkg::*;

    localparam int OB = OFFSET_BITS;

    // Configuration registers.
    logic [1:0]       nl_size_reg;
    logic [3:0][63:0] vmap_reg;

    // Parser state.
    parse_state_t     state_reg, state_next;
    logic [OB-1:0]    offset_reg, offset_next;
    logic [OB-1:0]    line_reg, line_next;
    logic [OB-1:0]    gap_reg, gap_next;
    logic [OB-1:0]    contig_reg, contig_next;
    logic [OB-1:0]    learned_reg, learned_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             paren_reg, paren_next;
    logic             regular_reg, regular_next;
    logic             open_reg, open_next;
    logic             halted_reg, halted_next;

    // Working values of the record builder.
    parse_state_t                       st_v;
    logic [2:0]                         cnt;
    logic [MAX_RECORDS-1:0][2:0]        kind_v;
    logic [MAX_RECORDS-1:0][OB-1:0]     pos_v;
    logic [MAX_RECORDS-1:0][7:0]        name_v;
    logic [OB-1:0]                      a_res_v, a_len_v, b_res_v, b_len_v;
    logic                               a_reg_v, b_reg_v;

    logic             byte_valid;
    logic [OB-1:0]    off_dec, off_inc, hdr_pos, seq_sum;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_size_reg <= NEWLINE_SIZE_RESET;
            vmap_reg[0] <= '0;
            vmap_reg[1] <= VALID_MAP_1_RESET;
            vmap_reg[2] <= '0;
            vmap_reg[3] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NEWLINE_SIZE: nl_size_reg <= cfg_data[1:0];
                CFG_VALID_MAP_0:  vmap_reg[0] <= cfg_data;
                CFG_VALID_MAP_1:  vmap_reg[1] <= cfg_data;
                CFG_VALID_MAP_2:  vmap_reg[2] <= cfg_data;
                CFG_VALID_MAP_3:  vmap_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Byte classification and offsets shared by several records.
    assign byte_valid = vmap_reg[in_byte[7:6]][in_byte[5:0]];
    assign off_dec    = offset_reg - OB'(1);
    assign off_inc    = offset_reg + OB'(1);
    assign hdr_pos    = offset_reg + ((in_byte == CH_CR) ? OB'(2) : OB'(1));
    assign seq_sum    = contig_reg + line_reg;

    // Next parser state and the records this byte causes, in emission order.
    always_comb
    begin
        offset_next     = offset_reg;
        line_next       = line_reg;
        gap_next        = gap_reg;
        contig_next     = contig_reg;
        learned_next    = learned_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        paren_next      = paren_reg;
        regular_next    = regular_reg;
        open_next       = open_reg;
        halted_next     = halted_reg;
        st_v            = state_reg;
        cnt             = '0;
        kind_v          = '0;
        pos_v           = '0;
        name_v          = '0;
        a_res_v         = '0;
        a_len_v         = '0;
        a_reg_v         = 1'b0;
        b_res_v         = '0;
        b_len_v         = '0;
        b_reg_v         = 1'b0;

        if (!halted_reg)
        begin
            // A residue before any header is an error that halts the file.
            if (st_v == PS_START)
            begin
                if (in_byte != CH_GT && byte_valid)
                begin
                    kind_v[cnt[1:0]] = K_BAD_START;
                    pos_v[cnt[1:0]]  = '0;
                    cnt              = cnt + 3'd1;
                    halted_next      = 1'b1;
                end
                else
                begin
                    st_v = PS_SEEK;
                end
            end

            // Sequence body: count residues and check the line layout.
            if (!halted_next && st_v == PS_SEQ)
            begin
                if (byte_valid)
                begin
                    if (gap_reg != '0)
                    begin
                        if (line_reg != learned_reg || gap_reg != OB'(nl_size_reg))
                        begin
                            regular_next = 1'b0;
                        end
                        contig_next = seq_sum;
                        line_next   = OB'(1);
                        gap_next    = '0;
                    end
                    else
                    begin
                        line_next = line_reg + OB'(1);
                    end
                end
                else if (in_byte == CH_GT)
                begin
                    kind_v[cnt[1:0]] = K_CONTIG_END;
                    pos_v[cnt[1:0]]  = off_dec;
                    cnt              = cnt + 3'd1;
                    a_res_v          = seq_sum;
                    a_len_v          = learned_reg;
                    a_reg_v          = regular_reg;
                    open_next        = 1'b0;
                    st_v             = PS_SEEK;
                end
                else if (is_newline(in_byte))
                begin
                    if (learned_reg == '0)
                    begin
                        learned_next = line_reg;
                    end
                    gap_next = gap_reg + OB'(1);
                end
                else
                begin
                    regular_next = 1'b0;
                end
            end

            if (!halted_next)
            begin
                unique case (st_v)
                    PS_SEEK:
                    begin
                        if (in_byte == CH_GT)
                        begin
                            kind_v[cnt[1:0]] = K_CONTIG_START;
                            pos_v[cnt[1:0]]  = offset_reg;
                            cnt              = cnt + 3'd1;
                            st_v             = PS_NAME;
                            paren_next       = 1'b0;
                            pend_valid_next  = 1'b0;
                            pend_byte_next   = '0;
                            regular_next     = 1'b1;
                            contig_next      = '0;
                            line_next        = '0;
                            gap_next         = '0;
                            open_next        = 1'b1;
                        end
                    end
                    PS_NAME:
                    begin
                        if (is_newline(in_byte) || in_byte == CH_SEMI)
                        begin
                            if (pend_valid_next)
                            begin
                                kind_v[cnt[1:0]] = K_NAME_BYTE;
                                pos_v[cnt[1:0]]  = off_dec;
                                name_v[cnt[1:0]] = pend_byte_next;
                                cnt              = cnt + 3'd1;
                            end
                            pend_valid_next  = 1'b0;
                            pend_byte_next   = '0;
                            kind_v[cnt[1:0]] = K_NAME_END;
                            pos_v[cnt[1:0]]  = offset_reg;
                            cnt              = cnt + 3'd1;
                            kind_v[cnt[1:0]] = K_HEADER_START;
                            pos_v[cnt[1:0]]  = hdr_pos;
                            cnt              = cnt + 3'd1;
                            st_v = (in_byte == CH_SEMI) ? PS_COMMENT : PS_LINE;
                        end
                        else if (in_byte == CH_LPAREN)
                        begin
                            // First parenthesis: drop a trailing space, then stop the name.
                            if (!paren_reg)
                            begin
                                if (pend_valid_next && is_space(pend_byte_next))
                                begin
                                    pend_valid_next = 1'b0;
                                    pend_byte_next  = '0;
                                end
                                if (pend_valid_next)
                                begin
                                    kind_v[cnt[1:0]] = K_NAME_BYTE;
                                    pos_v[cnt[1:0]]  = off_dec;
                                    name_v[cnt[1:0]] = pend_byte_next;
                                    cnt              = cnt + 3'd1;
                                end
                                pend_valid_next = 1'b0;
                                pend_byte_next  = '0;
                                paren_next      = 1'b1;
                            end
                        end
                        else if (!paren_reg && (!is_space(in_byte) || pend_valid_reg))
                        begin
                            // Emit the held byte and hold this one.
                            if (pend_valid_reg)
                            begin
                                kind_v[cnt[1:0]] = K_NAME_BYTE;
                                pos_v[cnt[1:0]]  = off_dec;
                                name_v[cnt[1:0]] = pend_byte_reg;
                                cnt              = cnt + 3'd1;
                            end
                            pend_byte_next  = in_byte;
                            pend_valid_next = 1'b1;
                        end
                    end
                    PS_COMMENT:
                    begin
                        if (is_newline(in_byte))
                        begin
                            st_v = PS_LINE;
                        end
                    end
                    PS_LINE:
                    begin
                        if (in_byte == CH_GT)
                        begin
                            st_v = PS_COMMENT;
                        end
                        else if (byte_valid)
                        begin
                            kind_v[cnt[1:0]] = K_SEQ_START;
                            pos_v[cnt[1:0]]  = offset_reg;
                            cnt              = cnt + 3'd1;
                            contig_next      = '0;
                            line_next        = OB'(1);
                            gap_next         = '0;
                            st_v             = PS_SEQ;
                        end
                    end
                    default: ;
                endcase
            end
        end

        offset_next = off_inc;

        // End of file: close the open contig, then return to the start state.
        if (last)
        begin
            if (!halted_next && open_next)
            begin
                if (st_v == PS_NAME)
                begin
                    if (pend_valid_next)
                    begin
                        kind_v[cnt[1:0]] = K_NAME_BYTE;
                        pos_v[cnt[1:0]]  = offset_reg;
                        name_v[cnt[1:0]] = pend_byte_next;
                        cnt              = cnt + 3'd1;
                    end
                    kind_v[cnt[1:0]] = K_NAME_END;
                    pos_v[cnt[1:0]]  = off_inc;
                    cnt              = cnt + 3'd1;
                end
                kind_v[cnt[1:0]] = K_CONTIG_END;
                pos_v[cnt[1:0]]  = off_inc;
                cnt              = cnt + 3'd1;
                b_res_v = (st_v == PS_SEQ) ? (contig_next + line_next) : contig_next;
                b_len_v = learned_next;
                b_reg_v = regular_next;
            end
            st_v            = PS_START;
            offset_next     = '0;
            line_next       = '0;
            gap_next        = '0;
            contig_next     = '0;
            learned_next    = '0;
            pend_byte_next  = '0;
            pend_valid_next = 1'b0;
            paren_next      = 1'b0;
            regular_next    = 1'b1;
            open_next       = 1'b0;
            halted_next     = 1'b0;
        end

        state_next = st_v;
    end

    // Parser state registers advance once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= PS_START;
            offset_reg     <= '0;
            line_reg       <= '0;
            gap_reg        <= '0;
            contig_reg     <= '0;
            learned_reg    <= '0;
            pend_byte_reg  <= '0;
            pend_valid_reg <= 1'b0;
            paren_reg      <= 1'b0;
            regular_reg    <= 1'b1;
            open_reg       <= 1'b0;
            halted_reg     <= 1'b0;
        end
        else if (byte_en)
        begin
            state_reg      <= state_next;
            offset_reg     <= offset_next;
            line_reg       <= line_next;
            gap_reg        <= gap_next;
            contig_reg     <= contig_next;
            learned_reg    <= learned_next;
            pend_byte_reg  <= pend_byte_next;
            pend_valid_reg <= pend_valid_next;
            paren_reg      <= paren_next;
            regular_reg    <= regular_next;
            open_reg       <= open_next;
            halted_reg     <= halted_next;
        end
    end

    // Bundle toward the queue; bytes that cause no record are not queued.
    assign wr_en         = byte_en && (cnt != '0);
    assign ctl.count     = cnt;
    assign ctl.kind      = kind_v;
    assign ctl.name_char = name_v;
    assign ctl.regular_a = a_reg_v;
    assign ctl.regular_b = b_reg_v;
    assign pos           = pos_v;
    assign end_a_res     = a_res_v;
    assign end_a_len     = a_len_v;
    assign end_b_res     = b_res_v;
    assign end_b_len     = b_len_v;

endmodule

// ----- sv/fip_queue.sv -----
// Short register queue of record bundles between the parser front end and
// the record serializer. No package dependencies.
module fip_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/fip_back.sv -----
// Back end of the FASTA index parser: walks the records of the bundle at
// the head of the queue and presents one record per word. Depends on fip_pkg.
module fip_back #(
    parameter int OFFSET_BITS = 40
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    head_empty,
    input  fip_pkg::rec_ctl_t                       head_ctl,
    input  logic [fip_pkg::MAX_RECORDS-1:0][OFFSET_BITS-1:0] head_pos,
    input  logic [OFFSET_BITS-1:0]                  head_a_res,
    input  logic [OFFSET_BITS-1:0]                  head_a_len,
    input  logic [OFFSET_BITS-1:0]                  head_b_res,
    input  logic [OFFSET_BITS-1:0]                  head_b_len,
    output logic                                    head_pop,
    input  logic                                    pop,
    output logic                                    empty,
    output logic [2:0]                              kind,
    output logic [OFFSET_BITS-1:0]                  position,
    output logic [7:0]                              name_char,
    output logic [OFFSET_BITS-1:0]                  residue_count,
    output logic [OFFSET_BITS-1:0]                  line_length,
    output logic                                    regular,
    output logic                                    done_res
);
    import fip_pkg::*;

    localparam int SLOT_W = $clog2(MAX_RECORDS);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              is_last, take, is_end, is_name;

    assign is_last  = ({1'b0, slot_reg} == head_ctl.count - 3'd1);
    assign take     = pop && !head_empty;
    assign head_pop = take && is_last;
    assign empty    = head_empty;

    // Slot index within the head bundle.
    always_comb
    begin
        slot_next = slot_reg;
        if (take)
        begin
            slot_next = is_last ? '0 : slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    // Record fields; a contig end in the last slot is the end-of-file close.
    assign kind      = head_ctl.kind[slot_reg];
    assign position  = head_pos[slot_reg];
    assign is_end    = (kind == K_CONTIG_END);
    assign is_name   = (kind == K_NAME_BYTE);
    assign name_char = is_name ? head_ctl.name_char[slot_reg] : '0;
    assign residue_count = !is_end ? '0 : (is_last ? head_b_res : head_a_res);
    assign line_length   = !is_end ? '0 : (is_last ? head_b_len : head_a_len);
    assign regular       = is_end && (is_last ? head_ctl.regular_b : head_ctl.regular_a);
    assign done_res      = is_last;

endmodule

// ----- sv/fasta_index_parser_unit.sv -----
// FASTA index parser top level. A byte accepted at one edge is queued at that edge;
// its first record is on the result ports after that edge if no earlier bundle waits.
// One byte per cycle is taken while the queue has room; a byte that causes k records
// holds the result side for k words, and a queue of QUEUE_DEPTH bundles buffers bursts.
// Reset clears the parser state and queue and loads the register defaults.
// Depends on fip_pkg, fip_front, fip_queue and fip_back.
module fasta_index_parser_unit #(
    parameter int OFFSET_BITS = 40,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             in_byte,
    input  logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   pop,
    output logic                   empty,
    output logic [2:0]             kind,
    output logic [OFFSET_BITS-1:0] position,
    output logic [7:0]             name_char,
    output logic [OFFSET_BITS-1:0] residue_count,
    output logic [OFFSET_BITS-1:0] line_length,
    output logic                   regular,
    output logic                   done_res
);
    import fip_pkg::*;

    localparam int OB     = OFFSET_BITS;
    localparam int CTL_W  = $bits(rec_ctl_t);
    localparam int Q_W    = CTL_W + (MAX_RECORDS + 4) * OB;

    logic                           byte_en;
    logic                           f_wr;
    rec_ctl_t                       f_ctl, h_ctl;
    logic [MAX_RECORDS-1:0][OB-1:0] f_pos, h_pos;
    logic [OB-1:0]                  f_a_res, f_a_len, f_b_res, f_b_len;
    logic [OB-1:0]                  h_a_res, h_a_len, h_b_res, h_b_len;
    logic [Q_W-1:0]                 q_wdata, q_rdata;
    logic                           q_full, q_empty, q_pop;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign byte_en   = push && !q_full;

    // Parser front end.
    fip_front #(
        .OFFSET_BITS(OB)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .in_byte   (in_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_en     (f_wr),
        .ctl       (f_ctl),
        .pos       (f_pos),
        .end_a_res (f_a_res),
        .end_a_len (f_a_len),
        .end_b_res (f_b_res),
        .end_b_len (f_b_len)
    );

    // Bundle queue between the two halves.
    assign q_wdata = {f_ctl, f_pos, f_a_res, f_a_len, f_b_res, f_b_len};
    assign {h_ctl, h_pos, h_a_res, h_a_len, h_b_res, h_b_len} = q_rdata;

    fip_queue #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_wr),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Record serializer.
    fip_back #(
        .OFFSET_BITS(OB)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_empty    (q_empty),
        .head_ctl      (h_ctl),
        .head_pos      (h_pos),
        .head_a_res    (h_a_res),
        .head_a_len    (h_a_len),
        .head_b_res    (h_b_res),
        .head_b_len    (h_b_len),
        .head_pop      (q_pop),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .position      (position),
        .name_char     (name_char),
        .residue_count (residue_count),
        .line_length   (line_length),
        .regular       (regular),
        .done_res      (done_res)
    );

endmodule

// ----- dv/fip_record_checker.sv -----
// Record checker for the FASTA index parser: predicts the index records from the
// accepted bytes and the register writes, then compares every popped word with them.
// Depends on fip_pkg for record kinds, parser states, register indexes and characters.
module fip_record_checker #(
    parameter int OFFSET_BITS = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  logic [7:0]             in_byte,
    input  logic                   last,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   pop,
    input  logic                   empty,
    input  logic [2:0]             kind,
    input  logic [OFFSET_BITS-1:0] position,
    input  logic [7:0]             name_char,
    input  logic [OFFSET_BITS-1:0] residue_count,
    input  logic [OFFSET_BITS-1:0] line_length,
    input  logic                   regular,
    input  logic                   done_res,
    output int                     fail_count,
    output int                     words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import fip_pkg::*;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        kind_t      kind;
        offset_t    position;
        logic [7:0] name_char;
        offset_t    residue_count;
        offset_t    line_length;
        logic       regular;
        logic       done_res;
    } index_rec_t;

    // Register copies, updated from the write channel.
    logic [1:0]  break_size;
    logic [63:0] base_map [4];

    // Parser state of the prediction.
    parse_state_t scan_state;
    offset_t      file_offset;
    offset_t      run_residues;
    offset_t      break_bytes;
    offset_t      contig_total;
    offset_t      first_line_len;
    logic [7:0]   held_char;
    logic         held_valid;
    logic         name_closed;
    logic         layout_ok;
    logic         in_contig;
    logic         stopped;

    // Records of the byte being indexed, then all records still owed by the block.
    index_rec_t byte_recs [$];
    index_rec_t due_records [$];
    index_rec_t head_rec;

    function automatic logic is_base(input logic [7:0] c);
        return base_map[c[7:6]][c[5:0]];
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF)
            || is_break(c);
    endfunction

    function automatic void emit(input kind_t k, input offset_t pos, input logic [7:0] ch,
                                 input offset_t res, input offset_t len, input logic lay);
        index_rec_t r;
        r.kind          = k;
        r.position      = pos;
        r.name_char     = ch;
        r.residue_count = res;
        r.line_length   = len;
        r.regular       = lay;
        r.done_res      = 1'b0;
        byte_recs = {byte_recs, r};
    endfunction

    // A held name character goes out once the next one shows it is not trailing.
    function automatic void flush_name(input offset_t pos);
        if (held_valid)
            emit(K_NAME_BYTE, pos, held_char, '0, '0, 1'b0);
        held_valid = 1'b0;
        held_char  = 8'h00;
    endfunction

    function automatic void close_contig(input offset_t pos, input offset_t res);
        emit(K_CONTIG_END, pos, 8'h00, res, first_line_len, layout_ok);
        in_contig = 1'b0;
    endfunction

    function automatic void clear_parser();
        scan_state     = PS_START;
        file_offset    = '0;
        run_residues   = '0;
        break_bytes    = '0;
        contig_total   = '0;
        first_line_len = '0;
        held_char      = 8'h00;
        held_valid     = 1'b0;
        name_closed    = 1'b0;
        layout_ok      = 1'b1;
        in_contig      = 1'b0;
        stopped        = 1'b0;
    endfunction

    // Work out the records that one accepted byte causes and queue them.
    function automatic void index_byte(input logic [7:0] b, input logic fin);
        offset_t here;
        offset_t after;
        here = file_offset;
        byte_recs.delete();
        if (!stopped) begin
            // A base before any header is a bad start; the rest of the file is ignored.
            if (scan_state == PS_START) begin
                if (b != CH_GT && is_base(b)) begin
                    emit(K_BAD_START, '0, 8'h00, '0, '0, 1'b0);
                    stopped = 1'b1;
                end else begin
                    scan_state = PS_SEEK;
                end
            end
            // Sequence lines: count residues and judge line lengths and break sizes.
            if (!stopped && scan_state == PS_SEQ) begin
                if (is_base(b)) begin
                    if (break_bytes != 0) begin
                        if (run_residues != first_line_len || break_bytes != break_size)
                            layout_ok = 1'b0;
                        contig_total = contig_total + run_residues;
                        run_residues = '0;
                        break_bytes  = '0;
                    end
                    run_residues = run_residues + 1'b1;
                end else if (b == CH_GT) begin
                    close_contig(here - 1'b1, contig_total + run_residues);
                    scan_state = PS_SEEK;
                end else if (is_break(b)) begin
                    if (first_line_len == 0)
                        first_line_len = run_residues;
                    break_bytes = break_bytes + 1'b1;
                end else begin
                    layout_ok = 1'b0;
                end
            end
            if (!stopped) begin
                case (scan_state)
                    PS_SEEK: begin
                        if (b == CH_GT) begin
                            emit(K_CONTIG_START, here, 8'h00, '0, '0, 1'b0);
                            scan_state   = PS_NAME;
                            name_closed  = 1'b0;
                            held_valid   = 1'b0;
                            held_char    = 8'h00;
                            layout_ok    = 1'b1;
                            contig_total = '0;
                            run_residues = '0;
                            break_bytes  = '0;
                            in_contig    = 1'b1;
                        end
                    end
                    PS_NAME: begin
                        if (is_break(b) || b == CH_SEMI) begin
                            flush_name(here - 1'b1);
                            emit(K_NAME_END, here, 8'h00, '0, '0, 1'b0);
                            emit(K_HEADER_START, here + ((b == CH_CR) ? 2 : 1), 8'h00,
                                 '0, '0, 1'b0);
                            scan_state = (b == CH_SEMI) ? PS_COMMENT : PS_LINE;
                        end else if (b == CH_LPAREN) begin
                            // Only the first parenthesis trims a trailing blank and ends the name.
                            if (!name_closed) begin
                                if (held_valid && is_blank(held_char)) begin
                                    held_valid = 1'b0;
                                    held_char  = 8'h00;
                                end
                                flush_name(here - 1'b1);
                                name_closed = 1'b1;
                            end
                        end else if (!name_closed && (!is_blank(b) || held_valid)) begin
                            flush_name(here - 1'b1);
                            held_char  = b;
                            held_valid = 1'b1;
                        end
                    end
                    PS_COMMENT: begin
                        if (is_break(b))
                            scan_state = PS_LINE;
                    end
                    PS_LINE: begin
                        if (b == CH_GT) begin
                            scan_state = PS_COMMENT;
                        end else if (is_base(b)) begin
                            emit(K_SEQ_START, here, 8'h00, '0, '0, 1'b0);
                            contig_total = '0;
                            run_residues = 1;
                            break_bytes  = '0;
                            scan_state   = PS_SEQ;
                        end
                    end
                    default: ;
                endcase
            end
        end
        after = here + 1'b1;
        file_offset = after;
        // The final byte closes whatever contig is open and starts a new file.
        if (fin) begin
            if (!stopped && in_contig) begin
                if (scan_state == PS_NAME) begin
                    flush_name(here);
                    emit(K_NAME_END, after, 8'h00, '0, '0, 1'b0);
                end
                if (scan_state == PS_SEQ)
                    close_contig(after, contig_total + run_residues);
                else
                    close_contig(after, contig_total);
            end
            clear_parser();
        end
        if (byte_recs.size() > 0)
            byte_recs[byte_recs.size() - 1].done_res = 1'b1;
        foreach (byte_recs[i])
            due_records = {due_records, byte_recs[i]};
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", what, want, got);
            fail_count++;
        end
    endfunction

    // Sample all three channels at the rising edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            break_size  = NEWLINE_SIZE_RESET;
            base_map[0] = '0;
            base_map[1] = VALID_MAP_1_RESET;
            base_map[2] = '0;
            base_map[3] = '0;
            clear_parser();
            due_records.delete();
            fail_count = 0;
            words_due  = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NEWLINE_SIZE: break_size  = cfg_data[1:0];
                    CFG_VALID_MAP_0:  base_map[0] = cfg_data;
                    CFG_VALID_MAP_1:  base_map[1] = cfg_data;
                    CFG_VALID_MAP_2:  base_map[2] = cfg_data;
                    CFG_VALID_MAP_3:  base_map[3] = cfg_data;
                    default: ;
                endcase
            end
            // A word popped now was produced before this edge, so compare it first.
            if (pop && !empty) begin
                if (due_records.size() == 0) begin
                    $error("word popped with no record expected, kind %0d", kind);
                    fail_count++;
                end else begin
                    head_rec = due_records.pop_front();
                    check_field("kind", head_rec.kind, kind);
                    check_field("position", head_rec.position, position);
                    check_field("name_char", head_rec.name_char, name_char);
                    check_field("residue_count", head_rec.residue_count, residue_count);
                    check_field("line_length", head_rec.line_length, line_length);
                    check_field("regular", head_rec.regular, regular);
                    check_field("done_res", head_rec.done_res, done_res);
                end
            end
            if (push && !full)
                index_byte(in_byte, last);
            words_due = due_records.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
// Top of the FASTA index parser testbench: clock, reset, byte and register stimulus
// and the final verdict. Depends on fip_pkg, fasta_index_parser_unit and
// fip_record_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fip_pkg::*;

    localparam int OB          = 40;
    localparam int CYCLE_LIMIT = 200000;

    // Directed file bytes, last flag on top: a bad start, a full file with name
    // trimming and both line break bytes, and a file that ends inside its name.
    localparam logic [8:0] DIRECTED [25] = '{
        {1'b0, "A"}, {1'b0, "x"}, {1'b1, 8'hFF},
        {1'b0, ">"}, {1'b0, " "}, {1'b0, "n"}, {1'b0, " "}, {1'b0, "("}, {1'b0, "("},
        {1'b0, 8'h0D}, {1'b0, 8'h0A}, {1'b0, "A"}, {1'b0, "C"}, {1'b0, 8'h0A},
        {1'b0, "G"}, {1'b0, "x"}, {1'b0, ">"}, {1'b0, "q"}, {1'b0, ";"},
        {1'b0, 8'h0A}, {1'b0, 8'h00}, {1'b0, "t"}, {1'b1, 8'hFF},
        {1'b0, ">"}, {1'b1, "z"}
    };

    logic          clk;
    logic          rst_n;
    logic          push;
    logic          full;
    logic [7:0]    in_byte;
    logic          last;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [63:0]   cfg_data;
    logic          pop;
    logic          empty;
    logic [2:0]    kind;
    logic [OB-1:0] position;
    logic [7:0]    name_char;
    logic [OB-1:0] residue_count;
    logic [OB-1:0] line_length;
    logic          regular;
    logic          done_res;
    int            fail_count;
    int            words_due;

    int            send_idle;
    int            recv_idle;
    int            cycle_count;
    logic [1:0]    nl_now;
    logic [63:0]   maps_now [4];
    logic [7:0]    file_bytes [$];

    fasta_index_parser_unit #(
        .OFFSET_BITS(OB)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .position      (position),
        .name_char     (name_char),
        .residue_count (residue_count),
        .line_length   (line_length),
        .regular       (regular),
        .done_res      (done_res)
    );

    fip_record_checker #(
        .OFFSET_BITS(OB)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .position      (position),
        .name_char     (name_char),
        .residue_count (residue_count),
        .line_length   (line_length),
        .regular       (regular),
        .done_res      (done_res),
        .fail_count    (fail_count),
        .words_due     (words_due)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver pops at random, one decision per falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one byte, idling first at random, and return at the falling edge after
    // it was taken.
    task automatic feed_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        last    <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == CFG_NEWLINE_SIZE)
            nl_now = val[1:0];
        else
            maps_now[idx - 1] = val;
    endtask

    // Wait until every predicted word has been popped, then keep waiting for bytes
    // that cause no word.
    task automatic settle();
        push <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Build one file: mostly well formed with random names and sequence lines,
    // sometimes cut short, sometimes plain noise.
    function automatic void compose_file();
        int         line_len;
        int         n_lines;
        int         len;
        int         tries;
        logic [7:0] c;
        file_bytes.delete();
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 12))
                file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
            return;
        end
        if ($urandom_range(0, 9) == 0)
            file_bytes = {file_bytes, CH_LF};
        line_len = $urandom_range(1, 6);
        repeat ($urandom_range(1, 3)) begin
            file_bytes = {file_bytes, CH_GT};
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 7))
                    0:       c = CH_SPACE;
                    1:       c = CH_TAB;
                    2:       c = CH_LPAREN;
                    3:       c = 8'($urandom_range(0, 255));
                    default: c = 8'($urandom_range(8'h61, 8'h7A));
                endcase
                file_bytes = {file_bytes, c};
            end
            // Header end: a comment, a CR LF pair or a plain LF.
            case ($urandom_range(0, 4))
                0: begin
                    file_bytes = {file_bytes, CH_SEMI};
                    repeat ($urandom_range(0, 3))
                        file_bytes = {file_bytes, 8'($urandom_range(8'h20, 8'h7E))};
                    file_bytes = {file_bytes, CH_LF};
                end
                1: begin
                    file_bytes = {file_bytes, CH_CR};
                    file_bytes = {file_bytes, CH_LF};
                end
                default: file_bytes = {file_bytes, CH_LF};
            endcase
            n_lines = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            for (int ln = 0; ln < n_lines; ln++) begin
                len = line_len;
                if (ln == n_lines - 1)
                    len = $urandom_range(1, line_len);
                if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(1, 7);
                for (int k = 0; k < len; k++) begin
                    // Draw up to 64 times until the byte is a base under the current maps.
                    c = "A";
                    for (tries = 0; tries < 64; tries++) begin
                        c = 8'($urandom_range(0, 255));
                        if (maps_now[c[7:6]][c[5:0]])
                            break;
                    end
                    if ($urandom_range(0, 29) == 0)
                        c = 8'($urandom_range(0, 255));
                    file_bytes = {file_bytes, c};
                end
                if (ln < n_lines - 1 || $urandom_range(0, 1) == 1) begin
                    if ((nl_now == 2) != ($urandom_range(0, 9) == 0))
                        file_bytes = {file_bytes, CH_CR};
                    file_bytes = {file_bytes, CH_LF};
                end
            end
        end
        if ($urandom_range(0, 9) == 0)
            while (file_bytes.size() > 1 && $urandom_range(0, 3) != 0)
                void'(file_bytes.pop_back());
    endfunction

    // Send random files until the byte budget is used; the final file is cut to fit.
    task automatic run_random(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            compose_file();
            while (file_bytes.size() > 1 && file_bytes.size() > budget - sent)
                void'(file_bytes.pop_back());
            foreach (file_bytes[i])
                feed_byte(file_bytes[i], i == file_bytes.size() - 1);
            sent += file_bytes.size();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        in_byte     = 8'h00;
        last        = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_NEWLINE_SIZE;
        cfg_data    = '0;
        send_idle   = 8;
        recv_idle   = 47;
        nl_now      = NEWLINE_SIZE_RESET;
        maps_now[0] = '0;
        maps_now[1] = VALID_MAP_1_RESET;
        maps_now[2] = '0;
        maps_now[3] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default registers: directed files, then random ones.
        foreach (DIRECTED[i])
            feed_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        run_random(45);
        settle();

        // CRLF breaks; bytes 0x00-0x3F and 0x80-0xBF all valid, 0xC0-0xFF at random.
        send_idle = 47;
        recv_idle = 8;
        write_reg(CFG_NEWLINE_SIZE, 64'd2);
        write_reg(CFG_VALID_MAP_0, '1);
        write_reg(CFG_VALID_MAP_1, '0);
        write_reg(CFG_VALID_MAP_2, '1);
        write_reg(CFG_VALID_MAP_3, {$urandom, $urandom});
        run_random(45);
        settle();

        // Break size of three: every line break is irregular.
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_NEWLINE_SIZE, 64'd3);
        write_reg(CFG_VALID_MAP_0, '0);
        write_reg(CFG_VALID_MAP_1, VALID_MAP_1_RESET);
        write_reg(CFG_VALID_MAP_2, '0);
        write_reg(CFG_VALID_MAP_3, '0);
        run_random(45);
        settle();

        // Break size of zero with random maps.
        write_reg(CFG_NEWLINE_SIZE, 64'd0);
        write_reg(CFG_VALID_MAP_1, VALID_MAP_1_RESET | {$urandom, $urandom});
        write_reg(CFG_VALID_MAP_2, {$urandom, $urandom});
        run_random(45);
        settle();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
